### hw/rtl/undirected_pagerank_engine_unit_macros.svh
// Assertion macros shared by the checker of the pagerank engine.
// Depends on nothing; the user scope must provide clock and reset.
`ifndef UNDIRECTED_PAGERANK_ENGINE_UNIT_MACROS_SVH
`define UNDIRECTED_PAGERANK_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define UPR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pagerank engine check failed");

// next-cycle implication
`define UPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pagerank engine check failed");

`endif

### hw/rtl/upr_pkg.sv
// Types and constants of the undirected pagerank engine.
// No dependencies; used by the request interface, top level, divider and checker.
package upr_pkg;

   localparam int MaxVertices   = 1024;
   localparam int VertexWidth   = 10;
   localparam int CountWidth    = 11;
   localparam int MaxEdges      = 4096;
   localparam int EdgeAddrWidth = 12;
   localparam int EdgeCntWidth  = 13;
   localparam int DegWidth      = 14;
   localparam int RankWidth     = 40;
   localparam int RankFracBits  = 32;
   localparam int DampWidth     = 16;
   localparam int IterWidth     = 8;
   localparam int DivCntWidth   = 6;
   localparam int CsrAddrWidth  = 4;
   localparam int CsrDataWidth  = 32;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_BAD_VERTEX  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_VERTEX_COUNT = 2'd0,
      REG_DAMPING      = 2'd1,
      REG_ITERATIONS   = 2'd2
   } reg_index_type;

endpackage

### hw/rtl/upr_req_if.sv
// Request channel of the pagerank engine: one command beat.
// Depends on upr_pkg.
interface upr_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic [upr_pkg::VertexWidth-1:0] vertex_a;
   logic [upr_pkg::VertexWidth-1:0] vertex_b;

   modport source (output valid, opcode, vertex_a, vertex_b, input ready);
   modport sink   (input valid, opcode, vertex_a, vertex_b, output ready);
endinterface

### hw/rtl/upr_rsp_if.sv
// Response channel of the pagerank engine: one result beat.
// Depends on nothing.
interface upr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rank;
   logic [1:0]  status;

   modport source (output valid, rank, status, input ready);
   modport sink   (input valid, rank, status, output ready);
endinterface

### hw/rtl/undirected_pagerank_engine_unit.sv
// Undirected pagerank engine, top level. A run has a degree pass, a pass that
// gives the vertices with edges their start values, then per iteration a scatter
// over the E stored edges and an update of the N vertices (the last iteration
// skips the divisions); its length is set by the one-read, one-write edge,
// degree, rank and accumulator memories and the bit-serial divider, which gives
// each vertex with edges one division per iteration.
// Depends on upr_pkg, upr_req_if, upr_rsp_if, upr_ram, upr_div.
module undirected_pagerank_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   upr_req_if.sink                              req_bus,
   upr_rsp_if.source                            rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [upr_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [upr_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [upr_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                 pready
);

   localparam int VW = upr_pkg::VertexWidth;
   localparam int CW = upr_pkg::CountWidth;
   localparam int RW = upr_pkg::RankWidth;
   localparam int DW = upr_pkg::DegWidth;
   localparam int EW = upr_pkg::EdgeAddrWidth;
   localparam int NW = upr_pkg::EdgeCntWidth;
   localparam int MW = upr_pkg::DampWidth;

   typedef enum logic [5:0] {
      S_IDLE, S_RD_DATA, S_FINISH,
      S_DCLR, S_DRD, S_DE, S_DA, S_DAW, S_DB, S_DBW,
      S_PSTART, S_PWAIT, S_IRD, S_ICHK, S_IDIV, S_PMASS,
      S_T2, S_BSTART, S_BWAIT, S_MASS, S_ACLR,
      S_SRD, S_SE, S_SCA, S_SCB, S_SAA, S_SAW, S_SBA, S_SBW,
      S_URD, S_UMUL, S_USEL, S_UDIV
   } state_type;

   state_type                 state_ff;
   logic [CW-1:0]             vcount_ff;
   logic [MW-1:0]             damp_ff;
   logic [upr_pkg::IterWidth-1:0] iter_ff, it_ff;
   logic [NW-1:0]             held_ff, e_ff;
   logic [VW-1:0]             v_ff, ea_ff, eb_ff;
   logic [RW-1:0]             ca_ff, cb_ff, p_ff, mass_ff, t2_ff, base_ff, prod_ff;
   logic [CW-1:0]             iso_ff;
   logic [DW-1:0]             deg_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_rank_ff, res_rank_ff;
   logic [1:0]                rsp_status_ff, res_status_ff;

   logic                      accept, csr_write;
   logic [CW-1:0]             n_minus1, wr_count;
   logic                      v_last, it_last, edge_ok, req_ok_a, req_ok_b;
   logic [RW-1:0]             x_val;
   logic [RW+MW-1:0]          t2_prod, acc_prod;

   logic                      edge_we, edge_re;
   logic [EW-1:0]             edge_waddr, edge_raddr;
   logic [2*VW-1:0]           edge_wdata, edge_rdata;
   logic                      deg_we, deg_re;
   logic [VW-1:0]             deg_waddr, deg_raddr;
   logic [DW-1:0]             deg_wdata, deg_rdata;
   logic                      cur_we, cur_re;
   logic [VW-1:0]             cur_waddr, cur_raddr;
   logic [RW-1:0]             cur_wdata, cur_rdata;
   logic                      acc_we, acc_re;
   logic [VW-1:0]             acc_waddr, acc_raddr;
   logic [RW-1:0]             acc_wdata, acc_rdata;

   logic                      div_start, div_done;
   logic [RW-1:0]             div_dividend, div_quotient;
   logic [DW-1:0]             div_divisor;

   assign accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign n_minus1  = vcount_ff - 1'b1;
   assign v_last    = ({1'b0, v_ff} == n_minus1);
   assign it_last   = (it_ff == iter_ff - 1'b1);
   assign req_ok_a  = ({1'b0, req_bus.vertex_a} < vcount_ff);
   assign req_ok_b  = ({1'b0, req_bus.vertex_b} < vcount_ff);
   assign edge_ok   = ({1'b0, edge_rdata[2*VW-1:VW]} < vcount_ff) &&
                      ({1'b0, edge_rdata[VW-1:0]} < vcount_ff);
   assign x_val     = base_ff + prod_ff;
   assign t2_prod   = mass_ff * damp_ff;
   assign acc_prod  = acc_rdata * damp_ff;

   always_comb begin
      wr_count = pwdata[CW-1:0];
      if (wr_count == '0) begin
         wr_count = CW'(1);
      end else if (wr_count > CW'(upr_pkg::MaxVertices)) begin
         wr_count = CW'(upr_pkg::MaxVertices);
      end
   end

   always_comb begin
      case (upr_pkg::reg_index_type'(paddr[3:2]))
         upr_pkg::REG_VERTEX_COUNT: prdata = 32'(vcount_ff);
         upr_pkg::REG_DAMPING:      prdata = 32'(damp_ff);
         upr_pkg::REG_ITERATIONS:   prdata = 32'(iter_ff);
         default:                   prdata = '0;
      endcase
   end

   // memory and divider control
   always_comb begin
      edge_we    = accept && (req_bus.opcode == upr_pkg::OP_ADD) && req_ok_a && req_ok_b
                   && !held_ff[NW-1];
      edge_waddr = held_ff[EW-1:0];
      edge_wdata = {req_bus.vertex_a, req_bus.vertex_b};
      edge_re    = (state_ff == S_DRD) || (state_ff == S_SRD);
      edge_raddr = e_ff[EW-1:0];

      deg_we = 1'b0; deg_waddr = v_ff; deg_wdata = '0;
      deg_re = 1'b0; deg_raddr = v_ff;
      cur_we = 1'b0; cur_waddr = v_ff; cur_wdata = p_ff;
      cur_re = 1'b0; cur_raddr = req_bus.vertex_a;
      acc_we = 1'b0; acc_waddr = v_ff; acc_wdata = '0;
      acc_re = 1'b0; acc_raddr = v_ff;
      div_start = 1'b0; div_dividend = p_ff; div_divisor = deg_ff;

      case (state_ff)
         S_IDLE: cur_re = 1'b1;
         S_DCLR: deg_we = 1'b1;
         S_DA:   begin deg_re = 1'b1; deg_raddr = ea_ff; end
         S_DAW:  begin deg_we = 1'b1; deg_waddr = ea_ff; deg_wdata = deg_rdata + 1'b1; end
         S_DB:   begin deg_re = 1'b1; deg_raddr = eb_ff; end
         S_DBW:  begin deg_we = 1'b1; deg_waddr = eb_ff; deg_wdata = deg_rdata + 1'b1; end
         S_PSTART: begin
            div_start    = 1'b1;
            div_dividend = RW'(64'd1 << upr_pkg::RankFracBits);
            div_divisor  = DW'(vcount_ff);
         end
         S_IRD: deg_re = 1'b1;
         S_ICHK: begin
            if (iter_ff == '0 || deg_rdata == '0) begin
               cur_we = 1'b1;
            end else begin
               div_start   = 1'b1;
               div_divisor = deg_rdata;
            end
         end
         S_IDIV: begin cur_we = div_done; cur_wdata = div_quotient; end
         S_BSTART: begin
            div_start    = 1'b1;
            div_dividend = RW'({(17'h10000 - {1'b0, damp_ff}), 16'h0}) + t2_ff;
            div_divisor  = DW'(vcount_ff);
         end
         S_ACLR: acc_we = 1'b1;
         S_SCA: begin cur_re = 1'b1; cur_raddr = ea_ff; end
         S_SCB: begin cur_re = 1'b1; cur_raddr = eb_ff; end
         S_SAA: begin acc_re = 1'b1; acc_raddr = ea_ff; end
         S_SAW: begin acc_we = 1'b1; acc_waddr = ea_ff; acc_wdata = acc_rdata + cb_ff; end
         S_SBA: begin acc_re = 1'b1; acc_raddr = eb_ff; end
         S_SBW: begin acc_we = 1'b1; acc_waddr = eb_ff; acc_wdata = acc_rdata + ca_ff; end
         S_URD: begin deg_re = 1'b1; acc_re = 1'b1; end
         S_USEL: begin
            if (deg_ff == '0) begin
               cur_we = 1'b1; cur_wdata = base_ff;
            end else if (it_last) begin
               cur_we = 1'b1; cur_wdata = x_val;
            end else begin
               div_start    = 1'b1;
               div_dividend = x_val;
            end
         end
         S_UDIV: begin cur_we = div_done; cur_wdata = div_quotient; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= CW'(1);
         damp_ff      <= MW'(55705);
         iter_ff      <= 8'd20;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (upr_pkg::reg_index_type'(paddr[3:2]))
               upr_pkg::REG_VERTEX_COUNT: vcount_ff <= wr_count;
               upr_pkg::REG_DAMPING:      damp_ff   <= pwdata[MW-1:0];
               upr_pkg::REG_ITERATIONS:   iter_ff   <= pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         if (edge_we) begin
            held_ff <= held_ff + 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_rank_ff   <= '0;
                  res_status_ff <= upr_pkg::ST_OK;
                  v_ff          <= '0;
                  e_ff          <= '0;
                  case (req_bus.opcode)
                     upr_pkg::OP_ADD: begin
                        if (!req_ok_a || !req_ok_b) begin
                           res_status_ff <= upr_pkg::ST_BAD_VERTEX;
                        end else if (held_ff[NW-1]) begin
                           res_status_ff <= upr_pkg::ST_FULL;
                        end
                        state_ff <= S_FINISH;
                     end
                     upr_pkg::OP_RUN: state_ff <= S_DCLR;
                     upr_pkg::OP_READ: begin
                        if (!req_ok_a) begin
                           res_status_ff <= upr_pkg::ST_BAD_VERTEX;
                           state_ff      <= S_FINISH;
                        end else begin
                           state_ff <= S_RD_DATA;
                        end
                     end
                     default: state_ff <= S_FINISH;
                  endcase
               end
            end
            S_RD_DATA: begin
               res_rank_ff <= (cur_rdata[RW-1:32] != '0) ? 32'hFFFF_FFFF : cur_rdata[31:0];
               state_ff    <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_rank_ff   <= res_rank_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            S_DCLR: begin
               v_ff <= v_ff + 1'b1;
               if (v_last) state_ff <= S_DRD;
            end
            S_DRD: state_ff <= (e_ff == held_ff) ? S_PSTART : S_DE;
            S_DE: begin
               ea_ff <= edge_rdata[2*VW-1:VW];
               eb_ff <= edge_rdata[VW-1:0];
               if (edge_ok) begin
                  state_ff <= S_DA;
               end else begin
                  e_ff     <= e_ff + 1'b1;
                  state_ff <= S_DRD;
               end
            end
            S_DA:  state_ff <= S_DAW;
            S_DAW: state_ff <= S_DB;
            S_DB:  state_ff <= S_DBW;
            S_DBW: begin
               e_ff     <= e_ff + 1'b1;
               state_ff <= S_DRD;
            end
            S_PSTART: state_ff <= S_PWAIT;
            S_PWAIT: begin
               if (div_done) begin
                  p_ff     <= div_quotient;
                  iso_ff   <= '0;
                  v_ff     <= '0;
                  state_ff <= S_IRD;
               end
            end
            S_IRD: state_ff <= S_ICHK;
            S_ICHK: begin
               if (deg_rdata == '0) iso_ff <= iso_ff + 1'b1;
               if (iter_ff == '0 || deg_rdata == '0) begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= v_last ? S_PMASS : S_IRD;
               end else begin
                  state_ff <= S_IDIV;
               end
            end
            S_IDIV: begin
               if (div_done) begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= v_last ? S_PMASS : S_IRD;
               end
            end
            S_PMASS: begin
               mass_ff  <= RW'(p_ff * iso_ff);
               it_ff    <= '0;
               state_ff <= (iter_ff == '0) ? S_FINISH : S_T2;
            end
            S_T2: begin
               t2_ff    <= t2_prod[RW+MW-1:MW];
               state_ff <= S_BSTART;
            end
            S_BSTART: state_ff <= S_BWAIT;
            S_BWAIT: begin
               if (div_done) begin
                  base_ff  <= div_quotient;
                  state_ff <= S_MASS;
               end
            end
            S_MASS: begin
               mass_ff  <= RW'(base_ff * iso_ff);
               v_ff     <= '0;
               state_ff <= S_ACLR;
            end
            S_ACLR: begin
               v_ff <= v_ff + 1'b1;
               if (v_last) begin
                  e_ff     <= '0;
                  state_ff <= S_SRD;
               end
            end
            S_SRD: begin
               if (e_ff == held_ff) begin
                  v_ff     <= '0;
                  state_ff <= S_URD;
               end else begin
                  state_ff <= S_SE;
               end
            end
            S_SE: begin
               ea_ff <= edge_rdata[2*VW-1:VW];
               eb_ff <= edge_rdata[VW-1:0];
               if (edge_ok) begin
                  state_ff <= S_SCA;
               end else begin
                  e_ff     <= e_ff + 1'b1;
                  state_ff <= S_SRD;
               end
            end
            S_SCA: state_ff <= S_SCB;
            S_SCB: begin
               ca_ff    <= cur_rdata;
               state_ff <= S_SAA;
            end
            S_SAA: begin
               cb_ff    <= cur_rdata;
               state_ff <= S_SAW;
            end
            S_SAW: state_ff <= S_SBA;
            S_SBA: state_ff <= S_SBW;
            S_SBW: begin
               e_ff     <= e_ff + 1'b1;
               state_ff <= S_SRD;
            end
            S_URD: state_ff <= S_UMUL;
            S_UMUL: begin
               deg_ff   <= deg_rdata;
               prod_ff  <= acc_prod[RW+MW-1:MW];
               state_ff <= S_USEL;
            end
            S_USEL: begin
               if (deg_ff == '0 || it_last) begin
                  v_ff <= v_ff + 1'b1;
                  if (v_last) begin
                     it_ff    <= it_ff + 1'b1;
                     state_ff <= it_last ? S_FINISH : S_T2;
                  end else begin
                     state_ff <= S_URD;
                  end
               end else begin
                  state_ff <= S_UDIV;
               end
            end
            S_UDIV: begin
               if (div_done) begin
                  v_ff <= v_ff + 1'b1;
                  if (v_last) begin
                     it_ff    <= it_ff + 1'b1;
                     state_ff <= S_T2;
                  end else begin
                     state_ff <= S_URD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.rank   = rsp_rank_ff;
   assign rsp_bus.status = rsp_status_ff;

   upr_ram #(.WIDTH(2*VW), .DEPTH(upr_pkg::MaxEdges)) u_edge_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata));

   upr_ram #(.WIDTH(DW), .DEPTH(upr_pkg::MaxVertices)) u_deg_ram (
      .clock(clock), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
      .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata));

   upr_ram #(.WIDTH(RW), .DEPTH(upr_pkg::MaxVertices)) u_cur_ram (
      .clock(clock), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
      .re(cur_re), .raddr(cur_raddr), .rdata(cur_rdata));

   upr_ram #(.WIDTH(RW), .DEPTH(upr_pkg::MaxVertices)) u_acc_ram (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata));

   upr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quotient));

endmodule

### hw/rtl/upr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module upr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/upr_div.sv
// Restoring divider, one quotient bit per cycle, for rank / degree and mass / N.
// Depends on upr_pkg.
module upr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [upr_pkg::RankWidth-1:0]   dividend,
   input  logic [upr_pkg::DegWidth-1:0]    divisor,
   output logic                            done,
   output logic [upr_pkg::RankWidth-1:0]   quotient
);

   localparam logic [upr_pkg::DivCntWidth-1:0] LastStep =
      upr_pkg::DivCntWidth'(upr_pkg::RankWidth - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [upr_pkg::DivCntWidth-1:0]   cnt_ff, cnt_in;
   logic [upr_pkg::RankWidth-1:0]     num_ff, num_in;
   logic [upr_pkg::DegWidth-1:0]      rem_ff, rem_in;
   logic [upr_pkg::DegWidth-1:0]      den_ff, den_in;
   logic [upr_pkg::DegWidth:0]        trial;
   logic                              ge;

   always_comb begin
      trial   = {rem_ff, num_ff[upr_pkg::RankWidth-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? upr_pkg::DegWidth'(trial - {1'b0, den_ff})
                     : trial[upr_pkg::DegWidth-1:0];
         num_in = {num_ff[upr_pkg::RankWidth-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

### hw/rtl/upr_checker.sv
// Port-level checks of the pagerank engine, bound to the top level.
// Depends on upr_pkg and the assertion macro header.
`include "undirected_pagerank_engine_unit_macros.svh"

module upr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rank,
   input logic [1:0]  rsp_status,
   input logic        pready
);

   `UPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `UPR_ASSERT_NEXT(a_busy_after_beat, req_valid && req_ready, !req_ready)
   `UPR_ASSERT_NOW(a_rank_ok_only, rsp_valid && rsp_rank != 32'h0, rsp_status == upr_pkg::ST_OK)
   `UPR_ASSERT_NOW(a_status_code, rsp_valid, rsp_status != 2'd3)
   `UPR_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind undirected_pagerank_engine_unit upr_checker u_upr_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_bus.valid), .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .rsp_rank(rsp_bus.rank), .rsp_status(rsp_bus.status),
   .pready(pready));
